@@ rtl/hrsp_pkg.sv @@
// shared types and constants for the hub route shortest path block
// no dependencies; imported by hrsp_ram users, the top level and its checker
package hrsp_pkg;

    localparam int NODE_W      = 10;
    localparam int WEIGHT_IN_W = 20;
    localparam int ACTION_W    = 2;
    localparam int COUNT_W     = 11;
    localparam int RESULT_W    = 32;
    localparam int IN_DATA_W   = 64;
    localparam int CFG_IDX_W   = 1;

    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_MAX_EDGES   = 4096;
    localparam int DEF_WEIGHT_BITS = 20;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 1'b0,
        CFG_HUB_NODE   = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_HUB,
        ST_SCAN,
        ST_SETTLE,
        ST_EREAD,
        ST_EWAIT,
        ST_ECHK,
        ST_QREAD,
        ST_QWAIT
    } state_t;

endpackage

@@ rtl/hub_route_shortest_paths.sv @@
// hub route shortest paths: edge store, two dijkstra runs through a hub, route queries
// depends on hrsp_pkg and hrsp_ram
//
// Edge adds and store clears are done in the idle state when taken. When the distance
// tables are current, a query reads both tables in ST_QREAD, and ST_QWAIT registers the
// result once the output register is free; the input is not ready in between. The first
// query after any stored edge add, clear or register write first rebuilds both tables,
// forward and reverse: per direction it clears the node table, seeds the hub, then for
// each settled node runs a linear scan, a settle write and a read of every stored edge,
// with a relax step when the edge leaves the settled node, all paced by the single read
// port of the active node distance table, one sequencer driving one add/compare unit.
// The block takes no request while rebuilding or answering; a finished result waits in
// the output register while new requests enter.
module hub_route_shortest_paths
    import hrsp_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_EDGES   = DEF_MAX_EDGES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // action[1:0], edge_from[11:2], edge_to[21:12], edge_weight[41:22],
    // query_src[51:42], query_dst[61:52], zero fill
    input  logic [IN_DATA_W-1:0] s_tdata,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [RESULT_W-1:0]  m_tdata,   // route_length[31:0]
    output logic                 m_tuser,   // unreachable
    // register writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data
);

    localparam int NB  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EB  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int DW  = WEIGHT_BITS + NB;       // longest simple path fits
    localparam int EW  = WEIGHT_BITS + 2 * NODE_W;
    localparam int NW  = DW + 2;                  // reach, settled, distance

    // request fields
    action_t                  in_action;
    logic [NODE_W-1:0]        in_from;
    logic [NODE_W-1:0]        in_to;
    logic [WEIGHT_IN_W-1:0]   in_weight;
    logic [NODE_W-1:0]        in_src;
    logic [NODE_W-1:0]        in_dst;

    assign in_action = action_t'(s_tdata[1:0]);
    assign in_from   = s_tdata[11:2];
    assign in_to     = s_tdata[21:12];
    assign in_weight = s_tdata[41:22];
    assign in_src    = s_tdata[51:42];
    assign in_dst    = s_tdata[61:52];

    // control and datapath registers
    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     node_count_reg, node_count_next;
    logic [NODE_W-1:0]      hub_reg, hub_next;
    logic [ETW-1:0]         edge_total_reg, edge_total_next;
    logic                   stale_reg, stale_next;     // tables need a rebuild
    logic                   dir_reg, dir_next;         // 0 forward, 1 reverse
    logic [NCW-1:0]         idx_reg, idx_next;         // init and scan address
    logic                   pend_reg, pend_next;       // scan read in flight
    logic [NB-1:0]          pidx_reg, pidx_next;
    logic                   found_reg, found_next;
    logic [NB-1:0]          best_reg, best_next;
    logic [DW-1:0]          best_dist_reg, best_dist_next;
    logic [ETW-1:0]         k_reg, k_next;             // edge walk position
    logic [NB-1:0]          tgt_reg, tgt_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [NODE_W-1:0]      src_reg, src_next;
    logic [NODE_W-1:0]      dst_reg, dst_next;
    logic                   out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0]    out_len_reg, out_len_next;
    logic                   out_unr_reg, out_unr_next;

    // memory ports
    logic          e_we;
    logic [EB-1:0] e_waddr, e_raddr;
    logic [EW-1:0] e_wdata, e_rdata;
    logic          n_we;
    logic [NB-1:0] n_waddr, n_raddr_f, n_raddr_t;
    logic [NW-1:0] n_wdata, n_rdata_f, n_rdata_t, n_rdata;

    hrsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    // dist_from_hub table
    hrsp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_from_ram (
        .clk   (clk),
        .we    (n_we && !dir_reg),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr_f),
        .rdata (n_rdata_f)
    );

    // dist_to_hub table
    hrsp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_to_ram (
        .clk   (clk),
        .we    (n_we && dir_reg),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr_t),
        .rdata (n_rdata_t)
    );

    assign n_rdata = dir_reg ? n_rdata_t : n_rdata_f;

    // active node count, clamped to 1 .. MAX_NODES
    logic [NCW-1:0] n_act;
    always_comb
    begin
        priority if (node_count_reg == '0)
            n_act = NCW'(1);
        else if (32'(node_count_reg) > 32'(MAX_NODES))
            n_act = NCW'(MAX_NODES);
        else
            n_act = NCW'(node_count_reg);
    end

    // stored edge fields and the direction view
    logic [NODE_W-1:0]      e_from, e_to, e_a, e_b;
    logic [WEIGHT_BITS-1:0] e_w;
    assign e_from = e_rdata[NODE_W-1:0];
    assign e_to   = e_rdata[2*NODE_W-1:NODE_W];
    assign e_w    = e_rdata[EW-1:2*NODE_W];
    assign e_a    = dir_reg ? e_to : e_from;
    assign e_b    = dir_reg ? e_from : e_to;

    logic edge_hit;
    assign edge_hit = (32'(e_a) == 32'(best_reg)) && (32'(e_a) < 32'(n_act))
                      && (32'(e_b) < 32'(n_act));

    // node entry fields
    logic          rd_reach, rd_settled;
    logic [DW-1:0] rd_dist;
    assign rd_reach   = n_rdata[NW-1];
    assign rd_settled = n_rdata[NW-2];
    assign rd_dist    = n_rdata[DW-1:0];

    // shared add and compare unit
    logic [DW-1:0] relax_dist;
    logic          relax_better;
    assign relax_dist   = best_dist_reg + DW'(w_reg);
    assign relax_better = !rd_reach || (relax_dist < rd_dist);

    logic scan_cand;
    assign scan_cand = pend_reg && rd_reach && !rd_settled
                       && (!found_reg || rd_dist < best_dist_reg);

    logic hub_ok;
    assign hub_ok = 32'(hub_reg) < 32'(n_act);

    logic last_edge;
    assign last_edge = (k_reg + ETW'(1)) == edge_total_reg;

    // query answer
    logic [DW:0]  q_sum;
    logic         q_unr;
    assign q_sum = {1'b0, n_rdata_t[DW-1:0]} + {1'b0, n_rdata_f[DW-1:0]};
    assign q_unr = (32'(src_reg) >= 32'(n_act)) || (32'(dst_reg) >= 32'(n_act))
                   || !n_rdata_t[NW-1] || !n_rdata_f[NW-1];

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && in_action == ACT_QUERY)
                    state_next = stale_reg ? ST_INIT : ST_QREAD;
            end
            ST_INIT:
            begin
                if (idx_reg + NCW'(1) == n_act)
                    state_next = ST_HUB;
            end
            ST_HUB:
            begin
                priority if (hub_ok)
                    state_next = ST_SCAN;
                else if (dir_reg)
                    state_next = ST_QREAD;
                else
                    state_next = ST_INIT;
            end
            ST_SCAN:
            begin
                if (idx_reg == n_act && !pend_reg)
                begin
                    priority if (found_reg)
                        state_next = ST_SETTLE;
                    else if (dir_reg)
                        state_next = ST_QREAD;
                    else
                        state_next = ST_INIT;
                end
            end
            ST_SETTLE:
            begin
                state_next = (edge_total_reg == '0) ? ST_SCAN : ST_EREAD;
            end
            ST_EREAD:
            begin
                state_next = ST_EWAIT;
            end
            ST_EWAIT:
            begin
                priority if (edge_hit)
                    state_next = ST_ECHK;
                else if (last_edge)
                    state_next = ST_SCAN;
                else
                    state_next = ST_EREAD;
            end
            ST_ECHK:
            begin
                state_next = last_edge ? ST_SCAN : ST_EREAD;
            end
            ST_QREAD:
            begin
                state_next = ST_QWAIT;
            end
            ST_QWAIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        node_count_next = node_count_reg;
        hub_next        = hub_reg;
        edge_total_next = edge_total_reg;
        stale_next      = stale_reg;
        dir_next        = dir_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pidx_next       = pidx_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_dist_next  = best_dist_reg;
        k_next          = k_reg;
        tgt_next        = tgt_reg;
        w_next          = w_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_len_next    = out_len_reg;
        out_unr_next    = out_unr_reg;

        s_tready  = (state_reg == ST_IDLE);
        e_we      = 1'b0;
        e_waddr   = EB'(edge_total_reg);
        e_wdata   = {WEIGHT_BITS'(in_weight), in_to, in_from};
        e_raddr   = EB'(k_reg);
        n_we      = 1'b0;
        n_waddr   = NB'(idx_reg);
        n_wdata   = '0;
        n_raddr_f = NB'(idx_reg);
        n_raddr_t = NB'(idx_reg);

        // the user must write registers only while idle; the block itself does not enforce this
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NODE_COUNT: node_count_next = cfg_data;
                CFG_HUB_NODE:   hub_next = cfg_data[NODE_W-1:0];
                default:        ;
            endcase
            stale_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    unique case (in_action)
                        ACT_ADD:
                        begin
                            if (32'(edge_total_reg) < 32'(MAX_EDGES))
                            begin
                                e_we            = 1'b1;
                                edge_total_next = edge_total_reg + ETW'(1);
                                stale_next      = 1'b1;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            edge_total_next = '0;
                            stale_next      = 1'b1;
                        end
                        ACT_QUERY:
                        begin
                            src_next = in_src;
                            dst_next = in_dst;
                            dir_next = 1'b0;
                            idx_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INIT:
            begin
                // clear reach, settled and distance of every active node
                n_we     = 1'b1;
                idx_next = idx_reg + NCW'(1);
            end
            ST_HUB:
            begin
                n_we      = hub_ok;
                n_waddr   = NB'(hub_reg);
                n_wdata   = {1'b1, 1'b0, DW'(0)};
                idx_next  = '0;
                found_next = 1'b0;
                if (!hub_ok)
                begin
                    dir_next = 1'b1;
                    if (dir_reg)
                        stale_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                // one read issued and one entry compared per cycle
                if (idx_reg != n_act)
                begin
                    pend_next = 1'b1;
                    pidx_next = NB'(idx_reg);
                    idx_next  = idx_reg + NCW'(1);
                end
                if (scan_cand)
                begin
                    found_next     = 1'b1;
                    best_next      = pidx_reg;
                    best_dist_next = rd_dist;
                end
                if (idx_reg == n_act && !pend_reg && !found_reg)
                begin
                    dir_next = 1'b1;
                    idx_next = '0;
                    if (dir_reg)
                        stale_next = 1'b0;
                end
            end
            ST_SETTLE:
            begin
                n_we       = 1'b1;
                n_waddr    = best_reg;
                n_wdata    = {1'b1, 1'b1, best_dist_reg};
                k_next     = '0;
                idx_next   = '0;
                found_next = 1'b0;
            end
            ST_EREAD:
            begin
                e_raddr = EB'(k_reg);
            end
            ST_EWAIT:
            begin
                n_raddr_f = NB'(e_b);
                n_raddr_t = NB'(e_b);
                tgt_next  = NB'(e_b);
                w_next    = e_w;
                if (!edge_hit)
                    k_next = k_reg + ETW'(1);
            end
            ST_ECHK:
            begin
                n_waddr = tgt_reg;
                n_wdata = {1'b1, rd_settled, relax_dist};
                n_we    = relax_better;
                k_next  = k_reg + ETW'(1);
            end
            ST_QREAD, ST_QWAIT:
            begin
                n_raddr_t = NB'(src_reg);
                n_raddr_f = NB'(dst_reg);
                if (state_reg == ST_QWAIT && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_unr_next   = q_unr;
                    priority if (q_unr)
                        out_len_next = '0;
                    else if (64'(q_sum) > 64'({RESULT_W{1'b1}}))
                        out_len_next = '1;
                    else
                        out_len_next = RESULT_W'(q_sum);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= COUNT_W'(1);
            hub_reg        <= '0;
            edge_total_reg <= '0;
            stale_reg      <= 1'b1;
            dir_reg        <= 1'b0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            hub_reg        <= hub_next;
            edge_total_reg <= edge_total_next;
            stale_reg      <= stale_next;
            dir_reg        <= dir_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            k_reg          <= k_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg      <= pidx_next;
        best_reg      <= best_next;
        best_dist_reg <= best_dist_next;
        tgt_reg       <= tgt_next;
        w_reg         <= w_next;
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        out_len_reg   <= out_len_next;
        out_unr_reg   <= out_unr_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_len_reg;
    assign m_tuser  = out_unr_reg;

endmodule

@@ rtl/hrsp_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module hrsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/hrsp_checker.sv @@
// port level checks for hub_route_shortest_paths, bound to the top level
// depends on hrsp_pkg
module hrsp_checker
    import hrsp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [IN_DATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [RESULT_W-1:0]  m_tdata,
    input logic                 m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a taken query request deasserts the input ready
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[1:0] == ACT_QUERY |=> !s_tready)
        else $error("request taken during query");

    // an unreachable route reports zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("unreachable route with nonzero length");

    // a new result appears only after the input was blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a query");

endmodule

bind hub_route_shortest_paths hrsp_checker u_hrsp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
